// ----- rtl/core/ssp_pkg.sv -----
// Package for the servo status packet receiver.
// Constants, codes, phase and sequencer types, controller/datapath structs.
// No dependencies.
`default_nettype none

package ssp_pkg;

    localparam int MAX_BODY   = 32;
    localparam int BODY_AW    = $clog2(MAX_BODY);
    localparam int ELAPSED_W  = 20;
    localparam int MIN_LEN    = 2;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = '1;
    localparam logic [ELAPSED_W-1:0] TIMEOUT_RESET = 20'd3000;
    localparam logic [7:0]           HDR_BYTE      = 8'hFF;

    localparam logic [1:0] OP_ARM  = 2'd0;
    localparam logic [1:0] OP_BYTE = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [2:0] CODE_OK       = 3'd0;
    localparam logic [2:0] CODE_NO_HDR   = 3'd1;
    localparam logic [2:0] CODE_TIMEOUT  = 3'd2;
    localparam logic [2:0] CODE_BAD_LEN  = 3'd3;
    localparam logic [2:0] CODE_CHECKSUM = 3'd4;
    localparam logic [2:0] CODE_WRONG_ID = 3'd5;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HUNT,
        PH_ID,
        PH_LEN,
        PH_BODY
    } phase_t;

    typedef enum logic [1:0] {
        SQ_IN,
        SQ_RD,
        SQ_PAR,
        SQ_STAT
    } seq_t;

    typedef struct packed {
        logic       arm;
        logic       tick;
        logic       hunt_byte;
        logic       take_id;
        logic       take_len;
        logic       take_body;
        logic       set_pend;
        logic       finish;
        logic       rd;
        logic       load_param;
        logic       load_status;
        logic [2:0] code;
    } ssp_cmd_t;

    typedef struct packed {
        logic tmo_zero;
        logic inc_ge;
        logic inc_gt;
        logic el_ge;
        logic byte_ff;
        logic prev_ff;
        logic len_ok;
        logic last_body;
        logic ck_ok;
        logic id_ok;
        logic n_zero;
        logic last_param;
        logic out_free;
    } ssp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/ssp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ssp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ssp_ctrl.sv -----
// Controller: packet phase and result sequencer for the status receiver.
// Depends on ssp_pkg; drives ssp_dp through ssp_cmd_t.
`default_nettype none

module ssp_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output      logic               s_tready,
    input  wire logic [1:0]         opcode,
    input  wire ssp_pkg::ssp_stat_t stat,
    output      ssp_pkg::ssp_cmd_t  cmd
);

    import ssp_pkg::*;

    phase_t     phase_reg, phase_next;
    seq_t       seq_reg, seq_next;
    logic       in_acc;
    logic       ev_fail;
    logic       ev_finish;
    logic [2:0] ev_code;

    assign s_tready = (seq_reg == SQ_IN);
    assign in_acc   = s_tvalid && s_tready;

    // event decode for the accepted item
    always_comb
    begin
        ev_fail   = 1'b0;
        ev_finish = 1'b0;
        ev_code   = CODE_OK;
        if (opcode == OP_ARM)
        begin
            ev_fail = stat.tmo_zero;
            ev_code = CODE_NO_HDR;
        end
        else if (opcode == OP_TICK && phase_reg != PH_IDLE)
        begin
            if (phase_reg == PH_HUNT)
            begin
                ev_fail = stat.inc_ge;
                ev_code = CODE_NO_HDR;
            end
            else
            begin
                ev_fail = stat.inc_gt;
                ev_code = CODE_TIMEOUT;
            end
        end
        else if (opcode == OP_BYTE)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    ev_fail = stat.el_ge;
                    ev_code = CODE_NO_HDR;
                end
                PH_LEN:
                begin
                    ev_fail = !stat.len_ok;
                    ev_code = CODE_BAD_LEN;
                end
                PH_BODY:
                begin
                    if (stat.last_body)
                    begin
                        if (!stat.ck_ok)
                        begin
                            ev_fail = 1'b1;
                            ev_code = CODE_CHECKSUM;
                        end
                        else if (!stat.id_ok)
                        begin
                            ev_fail = 1'b1;
                            ev_code = CODE_WRONG_ID;
                        end
                        else
                        begin
                            ev_finish = 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        seq_next   = seq_reg;
        unique case (seq_reg)
            SQ_IN:
            begin
                if (in_acc)
                begin
                    if (ev_fail)
                    begin
                        phase_next = PH_IDLE;
                        seq_next   = SQ_STAT;
                    end
                    else if (ev_finish)
                    begin
                        phase_next = PH_IDLE;
                        seq_next   = stat.n_zero ? SQ_STAT : SQ_RD;
                    end
                    else if (opcode == OP_ARM)
                    begin
                        phase_next = PH_HUNT;
                    end
                    else if (opcode == OP_BYTE)
                    begin
                        unique case (phase_reg)
                            PH_HUNT:
                            begin
                                if (stat.byte_ff && stat.prev_ff)
                                begin
                                    phase_next = PH_ID;
                                end
                            end
                            PH_ID:   phase_next = PH_LEN;
                            PH_LEN:  phase_next = PH_BODY;
                            default: phase_next = phase_reg;
                        endcase
                    end
                end
            end
            SQ_RD:   seq_next = SQ_PAR;
            SQ_PAR:
            begin
                if (stat.out_free)
                begin
                    seq_next = stat.last_param ? SQ_STAT : SQ_RD;
                end
            end
            SQ_STAT:
            begin
                if (stat.out_free)
                begin
                    seq_next = SQ_IN;
                end
            end
            default: seq_next = SQ_IN;
        endcase
    end

    // commands
    always_comb
    begin
        cmd      = '0;
        cmd.code = ev_code;
        unique case (seq_reg)
            SQ_IN:
            begin
                if (in_acc)
                begin
                    cmd.set_pend = ev_fail || ev_finish;
                    cmd.finish   = ev_finish;
                    if (opcode == OP_ARM)
                    begin
                        cmd.arm = 1'b1;
                    end
                    else if (opcode == OP_TICK && phase_reg != PH_IDLE)
                    begin
                        cmd.tick = 1'b1;
                    end
                    else if (opcode == OP_BYTE && !ev_fail)
                    begin
                        cmd.hunt_byte = (phase_reg == PH_HUNT);
                        cmd.take_id   = (phase_reg == PH_ID);
                        cmd.take_len  = (phase_reg == PH_LEN);
                        cmd.take_body = (phase_reg == PH_BODY);
                    end
                end
            end
            SQ_RD:   cmd.rd          = 1'b1;
            SQ_PAR:  cmd.load_param  = stat.out_free;
            SQ_STAT: cmd.load_status = stat.out_free;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            seq_reg   <= SQ_IN;
        end
        else
        begin
            phase_reg <= phase_next;
            seq_reg   <= seq_next;
        end
    end

`ifndef SYNTHESIS
    a_idle_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg != SQ_IN) |-> (phase_reg == PH_IDLE))
        else $error("packet phase active during result emission");
    a_fail_to_status: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && ev_fail) |=> (seq_reg == SQ_STAT))
        else $error("failure did not lead to status result");
    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_param || cmd.load_status) |-> stat.out_free)
        else $error("output register overwritten");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/ssp_dp.sv -----
// Datapath: timeout counter, header/id/length/checksum registers, body RAM
// and output register. Depends on ssp_pkg and ssp_ram; commanded by ssp_ctrl.
`default_nettype none

module ssp_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [ssp_pkg::ELAPSED_W-1:0]   cfg_data,
    input  wire logic [7:0]                      data_byte,
    input  wire logic [7:0]                      expected_id,
    input  wire logic [4:0]                      out_limit,
    input  wire ssp_pkg::ssp_cmd_t               cmd,
    output      ssp_pkg::ssp_stat_t              stat,
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    output      logic [23:0]                     m_tdata,
    output      logic                            m_tuser,
    output      logic                            m_tlast
);

    import ssp_pkg::*;

    logic [ELAPSED_W-1:0] tmo_reg;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [ELAPSED_W-1:0] elapsed_inc;
    logic                 prev_ff_reg;
    logic [7:0]           want_id_reg;
    logic [4:0]           limit_reg;
    logic [7:0]           got_id_reg;
    logic [BODY_AW:0]     body_len_reg;
    logic [BODY_AW:0]     byte_pos_reg;
    logic [7:0]           run_sum_reg;
    logic [2:0]           pend_code_reg;
    logic [4:0]           pend_cnt_reg;
    logic [4:0]           emit_idx_reg;
    logic [4:0]           emit_n_reg;
    logic [4:0]           np;
    logic [4:0]           n_emit;
    logic [7:0]           rdata;
    logic                 m_valid_reg;
    logic                 m_user_reg;
    logic                 m_last_reg;
    logic [7:0]           m_byte_reg;
    logic [4:0]           m_idx_reg;
    logic [2:0]           m_code_reg;
    logic [4:0]           m_cnt_reg;

    assign elapsed_inc = (elapsed_reg == ELAPSED_MAX) ? elapsed_reg
                                                      : elapsed_reg + 1'b1;
    assign np     = 5'(body_len_reg - (BODY_AW+1)'(MIN_LEN));
    assign n_emit = (np < limit_reg) ? np : limit_reg;

    always_comb
    begin
        stat.tmo_zero   = (tmo_reg == '0);
        stat.inc_ge     = (elapsed_inc >= tmo_reg);
        stat.inc_gt     = (elapsed_inc > tmo_reg);
        stat.el_ge      = (elapsed_reg >= tmo_reg);
        stat.byte_ff    = (data_byte == HDR_BYTE);
        stat.prev_ff    = prev_ff_reg;
        stat.len_ok     = (data_byte >= 8'(MIN_LEN)) && (data_byte <= 8'(MAX_BODY));
        stat.last_body  = ((byte_pos_reg + 1'b1) >= body_len_reg);
        stat.ck_ok      = (~run_sum_reg == data_byte);
        stat.id_ok      = (got_id_reg == want_id_reg);
        stat.n_zero     = (n_emit == '0);
        stat.last_param = ((emit_idx_reg + 1'b1) == emit_n_reg);
        stat.out_free   = !m_valid_reg || m_tready;
    end

    ssp_ram #(
        .WIDTH(8),
        .DEPTH(MAX_BODY)
    ) u_body (
        .clk  (clk),
        .we   (cmd.take_body),
        .waddr(byte_pos_reg[BODY_AW-1:0]),
        .wdata(data_byte),
        .re   (cmd.rd),
        .raddr(BODY_AW'(emit_idx_reg + 1'b1)),
        .rdata(rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tmo_reg      <= TIMEOUT_RESET;
            elapsed_reg  <= '0;
            prev_ff_reg  <= 1'b0;
            want_id_reg  <= '0;
            limit_reg    <= '0;
            got_id_reg   <= '0;
            body_len_reg <= '0;
            byte_pos_reg <= '0;
            run_sum_reg  <= '0;
            pend_code_reg <= CODE_OK;
            pend_cnt_reg <= '0;
            emit_idx_reg <= '0;
            emit_n_reg   <= '0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                tmo_reg <= cfg_data;
            end
            if (cmd.arm)
            begin
                want_id_reg  <= expected_id;
                limit_reg    <= out_limit;
                elapsed_reg  <= '0;
                prev_ff_reg  <= 1'b0;
                got_id_reg   <= '0;
                body_len_reg <= '0;
                byte_pos_reg <= '0;
                run_sum_reg  <= '0;
            end
            if (cmd.tick)
            begin
                elapsed_reg <= elapsed_inc;
            end
            if (cmd.hunt_byte)
            begin
                prev_ff_reg <= stat.byte_ff && !prev_ff_reg;
            end
            if (cmd.take_id)
            begin
                got_id_reg  <= data_byte;
                run_sum_reg <= data_byte;
            end
            if (cmd.take_len)
            begin
                body_len_reg <= data_byte[BODY_AW:0];
                run_sum_reg  <= run_sum_reg + data_byte;
                byte_pos_reg <= '0;
            end
            if (cmd.take_body)
            begin
                byte_pos_reg <= byte_pos_reg + 1'b1;
                run_sum_reg  <= run_sum_reg + data_byte;
            end
            if (cmd.set_pend)
            begin
                pend_code_reg <= cmd.code;
                pend_cnt_reg  <= cmd.finish ? np : 5'd0;
                emit_n_reg    <= cmd.finish ? n_emit : 5'd0;
                emit_idx_reg  <= '0;
            end
            if (cmd.load_param)
            begin
                emit_idx_reg <= emit_idx_reg + 1'b1;
            end
            if (cmd.load_param || cmd.load_status)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_param)
        begin
            m_user_reg <= 1'b0;
            m_last_reg <= 1'b0;
            m_byte_reg <= rdata;
            m_idx_reg  <= emit_idx_reg;
            m_code_reg <= CODE_OK;
            m_cnt_reg  <= pend_cnt_reg;
        end
        else if (cmd.load_status)
        begin
            m_user_reg <= 1'b1;
            m_last_reg <= 1'b1;
            m_byte_reg <= '0;
            m_idx_reg  <= '0;
            m_code_reg <= pend_code_reg;
            m_cnt_reg  <= pend_cnt_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {3'b000, m_cnt_reg, m_code_reg, m_idx_reg, m_byte_reg};

`ifndef SYNTHESIS
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_pos_reg <= body_len_reg || body_len_reg == '0)
        else $error("body position past length");
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_cnt_reg <= 5'(MAX_BODY - MIN_LEN)) && (emit_n_reg <= pend_cnt_reg))
        else $error("parameter count out of range");
    a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |-> (emit_idx_reg < emit_n_reg))
        else $error("parameter read beyond emit count");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/servo_status_packet_receiver.sv -----
// Servo-bus status packet receiver, top level.
// Instantiates ssp_ctrl and ssp_dp; depends on ssp_pkg.
//
// An arm transfer (tuser 0) latches the expected id and the parameter limit
// and starts a header hunt; byte transfers (tuser 1) and microsecond ticks
// (tuser 2) then drive the parse. A transfer that ends the transaction blocks
// input until its results are out: a failure gives one status transfer, a
// verified reply gives up to out_limit parameter transfers, each a body RAM
// read and then an output register load, then the status transfer with tlast.
// The body RAM needs no clearing after reset. Output back-pressure stalls the
// result sequence.
`default_nettype none

module servo_status_packet_receiver (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [ssp_pkg::ELAPSED_W-1:0] cfg_data,   // timeout_ticks
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    input  wire logic [23:0]                   s_tdata,    // data_byte, expected_id, out_limit
    input  wire logic [1:0]                    s_tuser,    // opcode
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    output      logic [23:0]                   m_tdata,    // param_byte, param_index,
                                                           // status_code, param_count
    output      logic                          m_tuser,    // is_status
    output      logic                          m_tlast     // last
);

    import ssp_pkg::*;

    ssp_cmd_t  cmd;
    ssp_stat_t stat;

    ssp_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .opcode  (s_tuser),
        .stat    (stat),
        .cmd     (cmd)
    );

    ssp_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .data_byte  (s_tdata[7:0]),
        .expected_id(s_tdata[15:8]),
        .out_limit  (s_tdata[20:16]),
        .cmd        (cmd),
        .stat       (stat),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire
